// ----- design/nrte_pkg.sv -----
`default_nettype none
package nrte_pkg;

    localparam int BODY_DEPTH = 68;
    localparam int COUNT_W    = $clog2(BODY_DEPTH + 1);
    localparam int HEADER_LEN = 5;
    localparam int N_CAPTURE  = 13;
    localparam int N_DIGITS   = 12;
    localparam int STATUS_IDX = 12;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_FIX_OK = 8'h41;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] TEN       = 8'd10;

    localparam logic [6:0] MIN_LEN_RESET = 7'd64;

    // Body offsets latched as they arrive: time digits, date digits, fix status
    localparam logic [N_CAPTURE-1:0][COUNT_W-1:0] CAP_OFFSET = {
        COUNT_W'(17),
        COUNT_W'(59), COUNT_W'(58), COUNT_W'(57), COUNT_W'(56), COUNT_W'(55), COUNT_W'(54),
        COUNT_W'(11), COUNT_W'(10), COUNT_W'(9),  COUNT_W'(8),  COUNT_W'(7),  COUNT_W'(6)
    };

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEAD,
        PH_BODY,
        PH_CHK_HI,
        PH_CHK_LO
    } phase_t;

    typedef struct packed {
        logic                       update;
        logic [N_DIGITS-1:0][7:0]   digits;
    } entry_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } q_status_t;

    function automatic logic [7:0] talker_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h47;
            3'd1:    c = 8'h50;
            3'd2:    c = 8'h52;
            3'd3:    c = 8'h4D;
            3'd4:    c = 8'h43;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] n;
        priority if (c >= 8'h30 && c <= 8'h39)
            n = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46)
            n = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66)
            n = 4'(c - 8'h57);
        else
            n = 4'h0;
        return n;
    endfunction

    function automatic logic [7:0] two_digits(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] hi;
        hi = 8'((a - CH_ZERO) * TEN);
        return 8'(hi + (b - CH_ZERO));
    endfunction

endpackage
`default_nettype wire

// ----- design/nrte_ifs.sv -----
`default_nettype none
interface nrte_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nrte_time_if;
    logic       valid;
    logic       ready;
    logic       time_update;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;

    modport source (output valid, output time_update, output hour, output minute,
                    output second, output day, output month, output year, input ready);
    modport sink   (input valid, input time_update, input hour, input minute,
                    input second, input day, input month, input year, output ready);
endinterface
`default_nettype wire

// ----- design/nrte_front.sv -----
`default_nettype none
module nrte_front
    import nrte_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_write_en,
    input  wire logic [6:0]    cfg_write_data,
    nrte_byte_if.sink          rx,
    input  wire q_status_t     q_status,
    output      logic          push,
    output      entry_t        push_entry
);

    phase_t                          phase_reg, phase_next;
    logic [COUNT_W-1:0]              count_reg, count_next;
    logic [7:0]                      xor_reg, xor_next;
    logic [7:0]                      chk_reg, chk_next;
    logic                            hdr_ok_reg, hdr_ok_next;
    logic [6:0]                      min_len_reg;
    logic [N_CAPTURE-1:0][7:0]       cap_reg;

    logic                            store_en;
    logic [COUNT_W-1:0]              count_inc;
    logic [7:0]                      chk_sum;
    logic                            hdr_ok_now;

    assign rx.ready = !q_status.full;
    assign push     = rx.valid && rx.ready;

    assign count_inc  = count_reg + COUNT_W'(1);
    assign chk_sum    = chk_reg + {4'h0, nibble_of(rx.rx_byte)};
    assign hdr_ok_now = hdr_ok_reg && (rx.rx_byte == talker_char(count_reg[2:0]));

    always_comb
    begin
        phase_next        = phase_reg;
        count_next        = count_reg;
        xor_next          = xor_reg;
        chk_next          = chk_reg;
        hdr_ok_next       = hdr_ok_reg;
        store_en          = 1'b0;
        push_entry.update = 1'b0;
        push_entry.digits = cap_reg[N_DIGITS-1:0];

        if (push)
        begin
            if (rx.rx_byte == CH_DOLLAR)
            begin
                phase_next  = PH_HEAD;
                count_next  = '0;
                xor_next    = '0;
                hdr_ok_next = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEAD:
                    begin
                        store_en    = 1'b1;
                        count_next  = count_inc;
                        xor_next    = xor_reg ^ rx.rx_byte;
                        hdr_ok_next = hdr_ok_now;
                        if (count_inc >= COUNT_W'(HEADER_LEN))
                        begin
                            if (hdr_ok_now)
                                phase_next = PH_BODY;
                            else
                            begin
                                phase_next = PH_IDLE;
                                count_next = '0;
                            end
                        end
                    end
                    PH_BODY:
                    begin
                        if (rx.rx_byte == CH_STAR)
                            phase_next = PH_CHK_HI;
                        else
                        begin
                            store_en   = 1'b1;
                            count_next = count_inc;
                            xor_next   = xor_reg ^ rx.rx_byte;
                            if (count_inc >= COUNT_W'(BODY_DEPTH))
                            begin
                                phase_next = PH_IDLE;
                                count_next = '0;
                            end
                        end
                    end
                    PH_CHK_HI:
                    begin
                        chk_next   = {nibble_of(rx.rx_byte), 4'h0};
                        phase_next = PH_CHK_LO;
                    end
                    PH_CHK_LO:
                    begin
                        chk_next          = chk_sum;
                        push_entry.update = (chk_sum == xor_reg)
                                         && (cap_reg[STATUS_IDX] == CH_FIX_OK)
                                         && (count_reg >= COUNT_W'(min_len_reg));
                        phase_next        = PH_IDLE;
                        count_next        = '0;
                    end
                    default:
                        phase_next = PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            count_reg   <= '0;
            xor_reg     <= '0;
            chk_reg     <= '0;
            hdr_ok_reg  <= 1'b0;
            min_len_reg <= MIN_LEN_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            xor_reg    <= xor_next;
            chk_reg    <= chk_next;
            hdr_ok_reg <= hdr_ok_next;
            if (cfg_write_en)
                min_len_reg <= cfg_write_data;
        end
    end

    // only the bytes at the field offsets are ever read back
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N_CAPTURE; i++)
        begin
            if (store_en && count_reg == CAP_OFFSET[i])
                cap_reg[i] <= rx.rx_byte;
        end
    end

endmodule
`default_nettype wire

// ----- design/nrte_queue.sv -----
`default_nettype none
module nrte_queue
    import nrte_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire entry_t    push_entry,
    input  wire logic      pop,
    output      entry_t    head,
    output      q_status_t status
);

    entry_t      slot_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  fill_reg;

    assign head            = slot_reg[rd_ptr_reg];
    assign status.full     = (fill_reg == 2'd2);
    assign status.nonempty = (fill_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule
`default_nettype wire

// ----- design/nrte_back.sv -----
`default_nettype none
module nrte_back
    import nrte_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire entry_t    head,
    input  wire q_status_t q_status,
    output      logic      pop,
    nrte_time_if.source    fix
);

    logic       valid_reg;
    logic       update_reg;
    logic [7:0] hour_reg, minute_reg, second_reg, day_reg, month_reg, year_reg;
    logic [7:0] hour_next, minute_next, second_next, day_next, month_next, year_next;

    assign pop = q_status.nonempty && (!valid_reg || fix.ready);

    always_comb
    begin
        hour_next   = '0;
        minute_next = '0;
        second_next = '0;
        day_next    = '0;
        month_next  = '0;
        year_next   = '0;
        if (head.update)
        begin
            hour_next   = two_digits(head.digits[0],  head.digits[1]);
            minute_next = two_digits(head.digits[2],  head.digits[3]);
            second_next = two_digits(head.digits[4],  head.digits[5]);
            day_next    = two_digits(head.digits[6],  head.digits[7]);
            month_next  = two_digits(head.digits[8],  head.digits[9]);
            year_next   = two_digits(head.digits[10], head.digits[11]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (fix.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            update_reg <= head.update;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            day_reg    <= day_next;
            month_reg  <= month_next;
            year_reg   <= year_next;
        end
    end

    assign fix.valid       = valid_reg;
    assign fix.time_update = update_reg;
    assign fix.hour        = hour_reg;
    assign fix.minute      = minute_reg;
    assign fix.second      = second_reg;
    assign fix.day         = day_reg;
    assign fix.month       = month_reg;
    assign fix.year        = year_reg;

endmodule
`default_nettype wire

// ----- design/nmea_rmc_time_extractor.sv -----
`default_nettype none
// Parses $GPRMC sentences one received byte per word and returns one result word
// for every byte taken; time_update is set on the word of the second checksum
// character when the checksum, the 'A' fix status and the minimum length all
// pass, otherwise every time field is zero. A byte is taken every cycle while the
// result side keeps up; with the result side stalled the two-entry queue between
// parser and output stage fills and the input stalls until a word leaves. A result
// word is written into a queue slot when its byte is taken and is registered into
// the output stage when it is popped. min_len_reg resets to 64.
module nmea_rmc_time_extractor
    import nrte_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write_en,
    input  wire logic [6:0] cfg_write_data,
    nrte_byte_if.sink       rx,
    nrte_time_if.source     fix
);

    logic      push, pop;
    entry_t    push_entry, head;
    q_status_t q_status;

    nrte_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .rx             (rx),
        .q_status       (q_status),
        .push           (push),
        .push_entry     (push_entry)
    );

    nrte_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    nrte_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .fix      (fix)
    );

`ifndef SYNTHESIS
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> q_status.nonempty)
        else $error("queue full yet empty");

    a_fill_from_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(q_status.full) |-> $past(push))
        else $error("queue filled without a push");

    a_no_update_zero: assert property (@(posedge clk) disable iff (!rst_n)
        fix.valid && !fix.time_update |-> fix.hour == 8'd0 && fix.minute == 8'd0
            && fix.second == 8'd0 && fix.day == 8'd0 && fix.month == 8'd0
            && fix.year == 8'd0)
        else $error("time fields set without update");
`endif

endmodule
`default_nettype wire

// ----- tb/nrte_fix_checker.sv -----
`timescale 1ns / 100ps
module nrte_fix_checker
    import nrte_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write_en,
    input  wire logic [6:0] cfg_write_data,
    nrte_byte_if            rx,
    nrte_time_if            fix,
    output int              fail_count,
    output int              outstanding
);

    localparam int          STATUS_AT = 17;
    localparam logic [39:0] TALKER    = "GPRMC";

    typedef struct packed {
        logic       time_update;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
    } fix_word_t;

    fix_word_t  due_words[$];
    phase_t     phase;
    int         stored;
    logic [7:0] sentence [BODY_DEPTH];
    logic [7:0] xor_sum;
    logic [7:0] sum_field;
    logic [6:0] min_len;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 4'(c - "0");
        if (c >= "A" && c <= "F")
            return 4'(c - "A" + 8'd10);
        if (c >= "a" && c <= "f")
            return 4'(c - "a" + 8'd10);
        return 4'h0;
    endfunction

    // two ASCII digits, wrapping at 256 for anything that is not a digit
    function automatic logic [7:0] digit_pair(input int at);
        logic [7:0] tens;
        logic [7:0] units;
        tens  = sentence[at] - 8'h30;
        units = sentence[at + 1] - 8'h30;
        return 8'(tens * 8'd10 + units);
    endfunction

    task automatic drop_sentence();
        phase  = PH_IDLE;
        stored = 0;
    endtask

    task automatic keep_byte(input logic [7:0] c);
        if (stored < BODY_DEPTH)
            sentence[stored] = c;
        stored++;
        xor_sum ^= c;
    endtask

    task automatic take_byte(input logic [7:0] c);
        fix_word_t result;
        result = '0;
        if (c == CH_DOLLAR)
        begin
            phase   = PH_HEAD;
            stored  = 0;
            xor_sum = '0;
        end
        else
        begin
            case (phase)
                PH_HEAD:
                begin
                    keep_byte(c);
                    if (stored >= HEADER_LEN)
                    begin
                        if ({sentence[0], sentence[1], sentence[2], sentence[3], sentence[4]}
                            == TALKER)
                            phase = PH_BODY;
                        else
                            drop_sentence();
                    end
                end
                PH_BODY:
                begin
                    if (c == CH_STAR)
                        phase = PH_CHK_HI;
                    else
                    begin
                        keep_byte(c);
                        if (stored >= BODY_DEPTH)
                            drop_sentence();
                    end
                end
                PH_CHK_HI:
                begin
                    sum_field = {hex_value(c), 4'h0};
                    phase     = PH_CHK_LO;
                end
                PH_CHK_LO:
                begin
                    sum_field = sum_field + {4'h0, hex_value(c)};
                    if (sum_field == xor_sum && sentence[STATUS_AT] == CH_FIX_OK
                        && stored >= min_len)
                    begin
                        result.time_update = 1'b1;
                        result.hour        = digit_pair(6);
                        result.minute      = digit_pair(8);
                        result.second      = digit_pair(10);
                        result.day         = digit_pair(54);
                        result.month       = digit_pair(56);
                        result.year        = digit_pair(58);
                    end
                    drop_sentence();
                end
                default:
                    phase = PH_IDLE;
            endcase
        end
        due_words.push_back(result);
    endtask

    task automatic compare(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_word();
        fix_word_t want;
        if (due_words.size() == 0)
        begin
            $error("result word with nothing expected");
            fail_count++;
        end
        else
        begin
            want = due_words.pop_front();
            compare("time_update", 8'(want.time_update), 8'(fix.time_update));
            compare("hour", want.hour, fix.hour);
            compare("minute", want.minute, fix.minute);
            compare("second", want.second, fix.second);
            compare("day", want.day, fix.day);
            compare("month", want.month, fix.month);
            compare("year", want.year, fix.year);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase       = PH_IDLE;
            stored      = 0;
            xor_sum     = '0;
            sum_field   = '0;
            min_len     = MIN_LEN_RESET;
            fail_count  = 0;
            outstanding = 0;
            due_words.delete();
        end
        else
        begin
            if (cfg_write_en)
                min_len = cfg_write_data;
            if (rx.valid && rx.ready)
                take_byte(rx.rx_byte);
            if (fix.valid && fix.ready)
                check_word();
            outstanding = due_words.size();
        end
    end

endmodule

// ----- tb/nmea_rmc_time_extractor_tb.sv -----
`timescale 1ns / 100ps
module nmea_rmc_time_extractor_tb;
    import nrte_pkg::*;

    typedef enum int { CS_GOOD, CS_BAD, CS_JUNK } csum_kind_t;

    localparam logic [39:0] TALKER    = "GPRMC";
    localparam int          STATUS_AT = 17;
    localparam int          MAX_WAIT  = 10;

    logic       clk;
    logic       rst_n;
    logic       cfg_write_en;
    logic [6:0] cfg_write_data;
    int         fail_count;
    int         outstanding;
    int         gap_max   = MAX_WAIT;
    int         stall_max = MAX_WAIT;
    int         sentence_bytes;
    logic [7:0] sentence_q[$];
    logic [6:0] min_plan [6] = '{7'd0, 7'd68, 7'd127, 7'd20, 7'd60, 7'd64};

    nrte_byte_if rx_if ();
    nrte_time_if fix_if ();

    nmea_rmc_time_extractor i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .rx             (rx_if),
        .fix            (fix_if)
    );

    nrte_fix_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .rx             (rx_if),
        .fix            (fix_if),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        #(5_000_000);
        $display("FAILURE");
        $finish;
    end

    function automatic logic [7:0] filler_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_DOLLAR || c == CH_STAR);
        return c;
    endfunction

    function automatic bit is_hex_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_hex_char(c) || c == CH_DOLLAR);
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic bit is_time_slot(input int i);
        return (i >= 6 && i <= 11) || (i >= 54 && i <= 59);
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 1))
            return $urandom_range(58, BODY_DEPTH - 1);
        return $urandom_range(0, BODY_DEPTH - 1);
    endfunction

    task automatic build_sentence(input int len, input bit head_ok, input bit fix_ok,
                                  input bit digits_ok, input csum_kind_t kind, input bit lower);
        logic [7:0] c;
        logic [7:0] sum;
        int         bad_at;
        sum    = '0;
        bad_at = head_ok ? -1 : $urandom_range(0, HEADER_LEN - 1);
        sentence_q.delete();
        sentence_q.push_back(CH_DOLLAR);
        for (int i = 0; i < len; i++)
        begin
            if (i < HEADER_LEN)
            begin
                c = TALKER[8 * (HEADER_LEN - 1 - i) +: 8];
                if (i == bad_at)
                    c = c ^ 8'h20;
            end
            else if (i == HEADER_LEN)
                c = ",";
            else if (is_time_slot(i))
                c = digits_ok ? 8'(8'h30 + $urandom_range(0, 9)) : filler_char();
            else if (i == STATUS_AT)
            begin
                c = CH_FIX_OK;
                if (!fix_ok)
                begin
                    do
                        c = filler_char();
                    while (c == CH_FIX_OK);
                end
            end
            else
                c = filler_char();
            sum ^= c;
            sentence_q.push_back(c);
        end
        sentence_q.push_back(CH_STAR);
        if (kind == CS_BAD)
            sum ^= 8'($urandom_range(1, 255));
        if (kind == CS_JUNK)
        begin
            sentence_q.push_back(junk_char());
            sentence_q.push_back($urandom_range(0, 1) ? junk_char() : hex_char(sum[3:0], lower));
        end
        else
        begin
            sentence_q.push_back(hex_char(sum[7:4], lower));
            sentence_q.push_back(hex_char(sum[3:0], lower));
        end
    endtask

    task automatic send_byte(input logic [7:0] c);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= c;
        do
            @(posedge clk);
        while (!rx_if.ready);
    endtask

    task automatic send_sentence();
        foreach (sentence_q[i])
            send_byte(sentence_q[i]);
        sentence_bytes += sentence_q.size();
    endtask

    // hold off until every result word is back
    task automatic settle();
        rx_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_min_len(input logic [6:0] value);
        settle();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    task automatic random_item();
        int pick;
        int cut;
        pick = $urandom_range(0, 99);
        if (pick < 65)
        begin
            build_sentence(pick_len(), 1'b1, $urandom_range(0, 7) != 0,
                           $urandom_range(0, 9) != 0, CS_GOOD, $urandom_range(0, 1));
            send_sentence();
        end
        else if (pick < 80)
        begin
            build_sentence(pick_len(), $urandom_range(0, 3) != 0, 1'b1, 1'b1,
                           $urandom_range(0, 1) ? CS_BAD : CS_JUNK, $urandom_range(0, 1));
            send_sentence();
        end
        else if (pick < 88)
        begin
            // cut short; the next '$' or stray bytes land mid-sentence
            build_sentence(pick_len(), 1'b1, 1'b1, 1'b1, CS_GOOD, 1'b0);
            cut = $urandom_range(0, sentence_q.size() - 2);
            sentence_q = sentence_q[0:cut];
            send_sentence();
        end
        else if (pick < 95)
        begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            build_sentence($urandom_range(BODY_DEPTH, BODY_DEPTH + 2), 1'b1, 1'b1, 1'b1,
                           CS_GOOD, 1'b0);
            send_sentence();
        end
    endtask

    initial
    begin
        fix_if.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            int stall;
            stall = $urandom_range(0, stall_max);
            if (stall > 0)
            begin
                fix_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            fix_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!fix_if.valid);
        end
    end

    initial
    begin
        int mark;
        bit paused;
        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= '0;
        rx_if.valid    <= 1'b0;
        rx_if.rx_byte  <= '0;
        sentence_bytes = 0;
        paused         = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray bytes while idle
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_STAR);
        send_byte(CH_FIX_OK);
        // longest body that fits; fills every time and date slot first
        build_sentence(BODY_DEPTH - 1, 1'b1, 1'b1, 1'b1, CS_GOOD, 1'b1);
        send_sentence();
        build_sentence(MIN_LEN_RESET, 1'b1, 1'b1, 1'b1, CS_GOOD, 1'b0);
        send_sentence();
        build_sentence(MIN_LEN_RESET - 1, 1'b1, 1'b1, 1'b1, CS_GOOD, 1'b0);
        send_sentence();
        // short sentences from here on
        set_min_len(7'd0);
        build_sentence(24, 1'b1, 1'b0, 1'b1, CS_GOOD, 1'b0);
        send_sentence();
        build_sentence(24, 1'b1, 1'b1, 1'b1, CS_BAD, 1'b1);
        send_sentence();
        build_sentence(24, 1'b1, 1'b1, 1'b1, CS_JUNK, 1'b0);
        send_sentence();
        build_sentence(24, 1'b1, 1'b1, 1'b0, CS_GOOD, 1'b1);
        send_sentence();
        build_sentence(24, 1'b0, 1'b1, 1'b1, CS_GOOD, 1'b0);
        send_sentence();
        // overflow: trailing '*' and checksum fall on an idle parser
        build_sentence(BODY_DEPTH, 1'b1, 1'b1, 1'b1, CS_GOOD, 1'b0);
        send_sentence();
        // restart mid-body, then mid-checksum
        build_sentence(40, 1'b1, 1'b1, 1'b1, CS_GOOD, 1'b0);
        sentence_q = sentence_q[0:30];
        send_sentence();
        build_sentence(40, 1'b1, 1'b1, 1'b1, CS_GOOD, 1'b1);
        void'(sentence_q.pop_back());
        send_sentence();
        build_sentence(40, 1'b1, 1'b1, 1'b1, CS_GOOD, 1'b0);
        sentence_q[3] = CH_STAR;
        send_sentence();
        build_sentence(40, 1'b1, 1'b1, 1'b1, CS_GOOD, 1'b1);
        send_sentence();
        // header alone, and '*' straight after '$'
        build_sentence(HEADER_LEN, 1'b1, 1'b1, 1'b1, CS_GOOD, 1'b0);
        send_sentence();
        build_sentence(0, 1'b1, 1'b1, 1'b1, CS_GOOD, 1'b0);
        send_sentence();

        foreach (min_plan[p])
        begin
            set_min_len(min_plan[p]);
            gap_max   = (p == 0 || p == 2) ? 0 : MAX_WAIT;
            stall_max = (p == 0 || p == 1) ? 0 : MAX_WAIT;
            mark      = sentence_bytes;
            while (sentence_bytes == mark)
            begin
                random_item();
                if (p == 3 && !paused)
                begin
                    settle();
                    paused = 1'b1;
                end
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
design/nrte_pkg.sv
design/nrte_ifs.sv
design/nrte_front.sv
design/nrte_queue.sv
design/nrte_back.sv
design/nmea_rmc_time_extractor.sv
tb/nrte_fix_checker.sv
tb/nmea_rmc_time_extractor_tb.sv
